[rtl/cffq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cffq_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int ID_SLOTS_DEF    = 8;
  localparam int DATA_GROUPS_DEF = 3;

  localparam int ID_W     = 29;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int TIME_W   = 32;
  localparam int LOC_W    = 10;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 6;
  localparam int PAIR_W   = 61;
  localparam int BYTES    = 8;
  localparam int MAX_LEN  = 8;
  localparam int ID_PAIRS = 4;
  localparam int GROUPS   = 3;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FILTERED = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_RX_EN = 3'd0,
    REG_ID0   = 3'd1,
    REG_ID1   = 3'd2,
    REG_ID2   = 3'd3,
    REG_ID3   = 3'd4,
    REG_GRP0  = 3'd5,
    REG_GRP1  = 3'd6,
    REG_GRP2  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_WB
  } state_t;

  // What one filter lane reports: whether its slot or group is in use, and
  // whether the frame matches it.
  typedef struct packed {
    logic active;
    logic hit;
  } lane_res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

[rtl/cffq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module cffq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/cffq_id_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module cffq_id_lane (
  input  wire logic [cffq_pkg::ID_W-1:0] slot,
  input  wire logic [cffq_pkg::ID_W-1:0] frame_id,
  output cffq_pkg::lane_res_t            res
);
  import cffq_pkg::*;

  // A zero slot is unused and never matches.
  assign res.active = (slot != '0);
  assign res.hit    = res.active && (slot == frame_id);

endmodule
`default_nettype wire

[rtl/cffq_grp_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module cffq_grp_lane (
  input  wire logic [cffq_pkg::DATA_W-1:0] pattern,
  input  wire logic [cffq_pkg::DATA_W-1:0] frame_data,
  output cffq_pkg::lane_res_t              res
);
  import cffq_pkg::*;

  logic [BYTES-1:0] byte_ok;

  // A zero pattern byte is a don't care.
  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      byte_ok[i] = (pattern[8*i +: 8] == 8'd0) || (pattern[8*i +: 8] == frame_data[8*i +: 8]);
    end
  end

  assign res.active = (pattern != '0);
  assign res.hit    = res.active && (&byte_ok);

endmodule
`default_nettype wire

[rtl/cffq_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
module cffq_filter #(
  parameter int ID_SLOTS    = cffq_pkg::ID_SLOTS_DEF,
  parameter int DATA_GROUPS = cffq_pkg::DATA_GROUPS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic [ID_SLOTS-1:0][cffq_pkg::ID_W-1:0]    slots,
  input  wire logic [DATA_GROUPS-1:0][cffq_pkg::DATA_W-1:0] groups,
  input  wire logic [cffq_pkg::ID_W-1:0]                  frame_id,
  input  wire logic [cffq_pkg::DATA_W-1:0]                frame_data,
  output logic                                            pass_r
);
  import cffq_pkg::*;

  lane_res_t id_res  [ID_SLOTS];
  lane_res_t grp_res [DATA_GROUPS];
  logic      id_ok;
  logic      data_ok;
  logic      pass_nxt;

  for (genvar k = 0; k < ID_SLOTS; k++) begin : g_id
    cffq_id_lane u_lane (
      .slot     (slots[k]),
      .frame_id (frame_id),
      .res      (id_res[k])
    );
  end

  for (genvar g = 0; g < DATA_GROUPS; g++) begin : g_grp
    cffq_grp_lane u_lane (
      .pattern    (groups[g]),
      .frame_data (frame_data),
      .res        (grp_res[g])
    );
  end

  // Merge: a filter with no active lane lets everything through.
  always_comb begin
    logic id_act, id_hit, g_act, g_hit;
    id_act = 1'b0;
    id_hit = 1'b0;
    g_act  = 1'b0;
    g_hit  = 1'b0;
    for (int k = 0; k < ID_SLOTS; k++) begin
      id_act = id_act | id_res[k].active;
      id_hit = id_hit | id_res[k].hit;
    end
    for (int g = 0; g < DATA_GROUPS; g++) begin
      g_act = g_act | grp_res[g].active;
      g_hit = g_hit | grp_res[g].hit;
    end
    id_ok    = !id_act || id_hit;
    data_ok  = !g_act || g_hit;
    pass_nxt = id_ok && data_ok;
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;
  end

endmodule
`default_nettype wire

[rtl/can_frame_filter_fifo_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A word accepted while idle goes through the capture registers, the filter
// register, the ring update and the registered read of the frame memory before
// the output register. No new word is taken while busy is high.
// The receiver cannot stall: each result word is shown for exactly one cycle.
// Reset (rst_n low, synchronous) clears the control state, pointers, counters and
// configuration registers; frame memory contents stay undefined and are never cleared.
module can_frame_filter_fifo_top #(
  parameter int DEPTH       = cffq_pkg::DEPTH_DEF,
  parameter int ID_SLOTS    = cffq_pkg::ID_SLOTS_DEF,
  parameter int DATA_GROUPS = cffq_pkg::DATA_GROUPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_action,
  input  wire logic [cffq_pkg::ID_W-1:0]      in_frame_id,
  input  wire logic [cffq_pkg::LEN_W-1:0]     in_frame_length,
  input  wire logic [cffq_pkg::DATA_W-1:0]    in_frame_data,
  input  wire logic [cffq_pkg::TIME_W-1:0]    in_frame_time,
  input  wire logic [cffq_pkg::LOC_W-1:0]     in_location,
  // Result channel
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [cffq_pkg::ID_W-1:0]           out_id,
  output logic [cffq_pkg::LEN_W-1:0]          out_length,
  output logic [cffq_pkg::DATA_W-1:0]         out_data,
  output logic [cffq_pkg::TIME_W-1:0]         out_time,
  output logic [cffq_pkg::LOC_W-1:0]          out_stored_count,
  output logic [cffq_pkg::TOTAL_W-1:0]        out_stored_total,
  output logic [cffq_pkg::TOTAL_W-1:0]        out_filtered_total,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cffq_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [cffq_pkg::CFG_W-1:0]     pwdata,
  output logic [cffq_pkg::CFG_W-1:0]          prdata,
  output logic                                pready
);
  import cffq_pkg::*;

  // Pointer width, and a scratch width that holds DEPTH as well as any peek offset.
  localparam int PW = $clog2(DEPTH);
  localparam int XW = ((PW > LOC_W) ? PW : LOC_W) + 1;
  localparam int EW = $bits(entry_t);

  // ---------------------------------------------------------------------------
  // Configuration registers. Every register sits at byte address 8*i, so the register
  // index is paddr[5:3]. Users write only while the block is idle; it does not check.
  // ---------------------------------------------------------------------------
  logic                                rx_en_r;
  logic [ID_PAIRS-1:0][PAIR_W-1:0]     id_pair_r;
  logic [GROUPS-1:0][DATA_W-1:0]       grp_r;
  reg_idx_t                            reg_idx;
  logic                                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_en_r   <= 1'b0;
      id_pair_r <= '0;
      grp_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RX_EN: rx_en_r      <= pwdata[0];
        REG_ID0:   id_pair_r[0] <= pwdata[PAIR_W-1:0];
        REG_ID1:   id_pair_r[1] <= pwdata[PAIR_W-1:0];
        REG_ID2:   id_pair_r[2] <= pwdata[PAIR_W-1:0];
        REG_ID3:   id_pair_r[3] <= pwdata[PAIR_W-1:0];
        REG_GRP0:  grp_r[0]     <= pwdata;
        REG_GRP1:  grp_r[1]     <= pwdata;
        REG_GRP2:  grp_r[2]     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RX_EN: prdata = {{(CFG_W-1){1'b0}}, rx_en_r};
      REG_ID0:   prdata = CFG_W'(id_pair_r[0]);
      REG_ID1:   prdata = CFG_W'(id_pair_r[1]);
      REG_ID2:   prdata = CFG_W'(id_pair_r[2]);
      REG_ID3:   prdata = CFG_W'(id_pair_r[3]);
      REG_GRP0:  prdata = grp_r[0];
      REG_GRP1:  prdata = grp_r[1];
      REG_GRP2:  prdata = grp_r[2];
    endcase
  end

  // ID slot k is the low or high half of pair k/2; only the first ID_SLOTS
  // slots and DATA_GROUPS groups feed filter lanes.
  logic [ID_SLOTS-1:0][ID_W-1:0]      slots;
  logic [DATA_GROUPS-1:0][DATA_W-1:0] groups;

  for (genvar k = 0; k < ID_SLOTS; k++) begin : g_slot
    assign slots[k] = id_pair_r[k / 2][(k % 2) * 32 +: ID_W];
  end
  for (genvar g = 0; g < DATA_GROUPS; g++) begin : g_group
    assign groups[g] = grp_r[g];
  end

  // ---------------------------------------------------------------------------
  // Command capture. The length saturates at eight and bytes beyond it are
  // zeroed here, so the filter and the stored frame both see the cleaned word.
  // ---------------------------------------------------------------------------
  action_t           act_r;
  logic [ID_W-1:0]   fid_r;
  logic [LEN_W-1:0]  flen_r;
  logic [DATA_W-1:0] fdat_r;
  logic [TIME_W-1:0] ftime_r;
  logic [LOC_W-1:0]  loc_r;
  logic [LEN_W-1:0]  len_sat;
  logic [DATA_W-1:0] dat_mask;
  logic              accept;

  assign accept  = start && !busy;
  assign len_sat = (in_frame_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_frame_length;

  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      dat_mask[8*i +: 8] = (LEN_W'(i) < len_sat) ? in_frame_data[8*i +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= action_t'(in_action);
      fid_r   <= in_frame_id;
      flen_r  <= len_sat;
      fdat_r  <= dat_mask;
      ftime_r <= in_frame_time;
      loc_r   <= in_location;
    end
  end

  // ---------------------------------------------------------------------------
  // Filter lanes work on the captured frame during the calculation cycle.
  // ---------------------------------------------------------------------------
  logic pass_r;

  cffq_filter #(
    .ID_SLOTS    (ID_SLOTS),
    .DATA_GROUPS (DATA_GROUPS)
  ) u_filter (
    .clk        (clk),
    .slots      (slots),
    .groups     (groups),
    .frame_id   (fid_r),
    .frame_data (fdat_r),
    .pass_r     (pass_r)
  );

  // ---------------------------------------------------------------------------
  // Ring state. The count is kept in its own register next to the pointers;
  // it never exceeds DEPTH-1, and a push into a full ring moves the read
  // pointer along so the oldest frame is lost.
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic [PW-1:0]      cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] stot_r, stot_nxt;
  logic [TOTAL_W-1:0] ftot_r, ftot_nxt;
  status_t            stat_r, stat_nxt;
  logic               in_range_r, in_range_nxt;
  logic [PW-1:0]      rd_addr_r, rd_addr_nxt;
  logic               ram_we;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic [EW-1:0]      rd_word;

  logic               out_valid_r;
  status_t            out_status_r;
  entry_t             out_entry_r;
  logic [LOC_W-1:0]   out_cnt_r;
  logic [TOTAL_W-1:0] out_stot_r;
  logic [TOTAL_W-1:0] out_ftot_r;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Peek offset check and address, worked out in the calculation cycle.
  always_comb begin
    logic [XW-1:0] loc_x, sum_x;
    loc_x        = (act_r == ACT_PEEK) ? XW'(loc_r) : '0;
    in_range_nxt = loc_x < XW'(cnt_r);
    sum_x        = XW'(rp_r) + loc_x;
    if (sum_x >= XW'(DEPTH)) begin
      sum_x = sum_x - XW'(DEPTH);
    end
    rd_addr_nxt = sum_x[PW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    cnt_nxt   = cnt_r;
    stot_nxt  = stot_r;
    ftot_nxt  = ftot_r;
    stat_nxt  = stat_r;
    ram_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_WB;
        stat_nxt  = ST_DONE;
        unique case (act_r)
          ACT_PUSH: begin
            if (!rx_en_r) begin
              stat_nxt = ST_DISABLED;
            end else if ((flen_r != '0) && !pass_r) begin
              stat_nxt = ST_FILTERED;
              ftot_nxt = ftot_r + TOTAL_W'(1);
            end else begin
              ram_we   = 1'b1;
              wp_nxt   = ring_next(wp_r);
              stot_nxt = stot_r + TOTAL_W'(1);
              if (cnt_r == PW'(DEPTH - 1)) begin
                rp_nxt = ring_next(rp_r);
              end else begin
                cnt_nxt = cnt_r + PW'(1);
              end
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (!in_range_r) begin
              stat_nxt = ST_EMPTY;
            end else if (act_r == ACT_POP) begin
              rp_nxt  = ring_next(rp_r);
              cnt_nxt = cnt_r - PW'(1);
            end
          end
          ACT_CLEAR: begin
            rp_nxt   = wp_r;
            cnt_nxt  = '0;
            stot_nxt = '0;
            ftot_nxt = '0;
          end
        endcase
      end
      S_WB: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      stot_r  <= '0;
      ftot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
      stot_r  <= stot_nxt;
      ftot_r  <= ftot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    if (state_r == S_CALC) begin
      in_range_r <= in_range_nxt;
      rd_addr_r  <= rd_addr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame memory: one entry holds id, length, data and timestamp. The read
  // address is settled in the calculation cycle, so the word is on rd_word
  // during write-back.
  // ---------------------------------------------------------------------------
  assign wr_entry.id    = fid_r;
  assign wr_entry.len   = flen_r;
  assign wr_entry.data  = fdat_r;
  assign wr_entry.stamp = ftime_r;
  assign rd_entry       = entry_t'(rd_word);

  cffq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (wr_entry),
    .raddr (rd_addr_r),
    .rdata (rd_word)
  );

  // ---------------------------------------------------------------------------
  // Output register: frame fields are zero unless a pop or peek succeeded.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) begin
      logic [XW-1:0] cnt_x;
      cnt_x        = XW'(cnt_r);
      out_status_r <= stat_r;
      if (((act_r == ACT_POP) || (act_r == ACT_PEEK)) && (stat_r == ST_DONE)) begin
        out_entry_r <= rd_entry;
      end else begin
        out_entry_r <= '0;
      end
      out_cnt_r  <= cnt_x[LOC_W-1:0];
      out_stot_r <= stot_r;
      out_ftot_r <= ftot_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_id             = out_entry_r.id;
  assign out_length         = out_entry_r.len;
  assign out_data           = out_entry_r.data;
  assign out_time           = out_entry_r.stamp;
  assign out_stored_count   = out_cnt_r;
  assign out_stored_total   = out_stot_r;
  assign out_filtered_total = out_ftot_r;

  // ---------------------------------------------------------------------------
  // Checks on the sequencer and ring bookkeeping.
  // ---------------------------------------------------------------------------
  a_wb_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_valid_r)
    else $error("write-back cycle not followed by a result strobe");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) < XW'(DEPTH))
    else $error("ring count reached DEPTH");

  a_fail_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DONE)) |-> ((out_id == '0) && (out_data == '0)))
    else $error("frame fields nonzero on a failed action");

  a_write_only_push: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((act_r == ACT_PUSH) && rx_en_r && (state_r == S_EXEC)))
    else $error("frame memory written outside an enabled push");

endmodule
`default_nettype wire

[tb/can_frame_filter_fifo_top_tb.sv]
`timescale 1ns / 1ps
module can_frame_filter_fifo_top_tb;
  import cffq_pkg::*;

  // One command word as it goes onto the in_ ports.
  typedef struct {
    action_t            act;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
    logic [TIME_W-1:0]  stamp;
    logic [LOC_W-1:0]   loc;
  } can_cmd_t;

  // One result word as the block should report it.
  typedef struct {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [LEN_W-1:0]    len;
    logic [DATA_W-1:0]   data;
    logic [TIME_W-1:0]   stamp;
    logic [LOC_W-1:0]    count;
    logic [TOTAL_W-1:0]  stored;
    logic [TOTAL_W-1:0]  filtered;
  } frame_report_t;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam logic [ID_W-1:0] ID_MAX = '1;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  logic [1:0]          in_action       = '0;
  logic [ID_W-1:0]     in_frame_id     = '0;
  logic [LEN_W-1:0]    in_frame_length = '0;
  logic [DATA_W-1:0]   in_frame_data   = '0;
  logic [TIME_W-1:0]   in_frame_time   = '0;
  logic [LOC_W-1:0]    in_location     = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_id;
  logic [LEN_W-1:0]    out_length;
  logic [DATA_W-1:0]   out_data;
  logic [TIME_W-1:0]   out_time;
  logic [LOC_W-1:0]    out_stored_count;
  logic [TOTAL_W-1:0]  out_stored_total;
  logic [TOTAL_W-1:0]  out_filtered_total;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [CFG_W-1:0]    pwdata  = '0;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  can_frame_filter_fifo_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_frame_id        (in_frame_id),
    .in_frame_length    (in_frame_length),
    .in_frame_data      (in_frame_data),
    .in_frame_time      (in_frame_time),
    .in_location        (in_location),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_id             (out_id),
    .out_length         (out_length),
    .out_data           (out_data),
    .out_time           (out_time),
    .out_stored_count   (out_stored_count),
    .out_stored_total   (out_stored_total),
    .out_filtered_total (out_filtered_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: ends a run that hangs and reports it as failed.
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration, ring contents, pointers and counters.
  // The pointers are ten bits wide, so their natural wrap is the ring wrap.
  // ---------------------------------------------------------------------------
  logic                shadow_rx_en;
  logic [PAIR_W-1:0]   shadow_id_pairs [ID_PAIRS];
  logic [DATA_W-1:0]   shadow_groups [GROUPS];
  entry_t              ring_mem [RING_DEPTH];
  logic [LOC_W-1:0]    wr_ptr;
  logic [LOC_W-1:0]    rd_ptr;
  logic [TOTAL_W-1:0]  stored_cnt;
  logic [TOTAL_W-1:0]  reject_cnt;

  can_cmd_t            command_backlog [$];
  frame_report_t       predicted_reports [$];
  int                  fail_count = 0;
  bit                  steady_feed = 1'b0;

  // Filter slot k of the ID whitelist; the odd slot of a pair sits in the upper half.
  function automatic logic [ID_W-1:0] id_slot(int k);
    logic [PAIR_W-1:0] pair;
    pair = shadow_id_pairs[k >> 1];
    return (k % 2) ? pair[32 +: ID_W] : pair[0 +: ID_W];
  endfunction

  // The whitelist is active once any slot is nonzero; a zero slot never matches.
  function automatic bit id_accepts(logic [ID_W-1:0] id);
    bit any_used;
    any_used = 1'b0;
    for (int k = 0; k < ID_SLOTS_DEF; k++) begin
      if (id_slot(k) != '0) begin
        any_used = 1'b1;
        if (id_slot(k) == id) return 1'b1;
      end
    end
    return !any_used;
  endfunction

  // A group passes when every nonzero pattern byte equals the frame byte.
  function automatic bit data_accepts(logic [DATA_W-1:0] dat);
    bit any_used;
    bit all_hit;
    logic [7:0] pb;
    any_used = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      if (shadow_groups[g] != '0) begin
        any_used = 1'b1;
        all_hit = 1'b1;
        for (int i = 0; i < BYTES; i++) begin
          pb = shadow_groups[g][8*i +: 8];
          if (pb != 8'd0 && pb != dat[8*i +: 8]) all_hit = 1'b0;
        end
        if (all_hit) return 1'b1;
      end
    end
    return !any_used;
  endfunction

  // Advances the shadow by one accepted command word and returns its report.
  function automatic frame_report_t apply_command(can_cmd_t c);
    frame_report_t r;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] dat;
    logic [LOC_W-1:0]  loc;
    logic [LOC_W-1:0]  fill;
    entry_t            e;
    r.status = ST_DONE;
    r.id     = '0;
    r.len    = '0;
    r.data   = '0;
    r.stamp  = '0;
    fill     = wr_ptr - rd_ptr;
    case (c.act)
      ACT_PUSH: begin
        // Overlong frames saturate; bytes past the length are dropped.
        len = (c.len > MAX_LEN) ? LEN_W'(MAX_LEN) : c.len;
        dat = c.data;
        if (len < MAX_LEN) dat = dat & ((64'd1 << (8 * len)) - 64'd1);
        if (!shadow_rx_en) begin
          r.status = ST_DISABLED;
        end else if (len != '0 && (!id_accepts(c.id) || !data_accepts(dat))) begin
          reject_cnt++;
          r.status = ST_FILTERED;
        end else begin
          // A full ring drops its oldest frame to make room.
          if (fill >= LOC_W'(RING_DEPTH - 1)) rd_ptr++;
          e.id    = c.id;
          e.len   = len;
          e.data  = dat;
          e.stamp = c.stamp;
          ring_mem[wr_ptr] = e;
          wr_ptr++;
          stored_cnt++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        loc = (c.act == ACT_PEEK) ? c.loc : '0;
        if (loc >= fill) begin
          r.status = ST_EMPTY;
        end else begin
          e = ring_mem[LOC_W'(rd_ptr + loc)];
          r.id    = e.id;
          r.len   = e.len;
          r.data  = e.data;
          r.stamp = e.stamp;
          if (c.act == ACT_POP) rd_ptr++;
        end
      end
      default: begin
        rd_ptr     = wr_ptr;
        stored_cnt = '0;
        reject_cnt = '0;
      end
    endcase
    r.count    = wr_ptr - rd_ptr;
    r.stored   = stored_cnt;
    r.filtered = reject_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pulls command words from the backlog, holds start until the word is
  // taken, then idles for a random gap. A gap that ends inside the block's busy
  // window raises start while busy is high; a longer one leaves it idle with start low.
  // ---------------------------------------------------------------------------
  can_cmd_t cur_cmd;
  bit       cmd_live = 1'b0;
  int       gap_left = 0;

  function automatic int gap_cycles();
    int pick;
    if (steady_feed) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      cmd_live = 1'b0;
      gap_left = 0;
    end else begin
      // The word on the ports is taken at this edge when busy was low.
      if (cmd_live && !busy) begin
        predicted_reports.push_back(apply_command(cur_cmd));
        cmd_live = 1'b0;
        gap_left = gap_cycles();
      end
      if (!cmd_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (command_backlog.size() > 0) begin
          cur_cmd  = command_backlog.pop_front();
          cmd_live = 1'b1;
          in_action       <= cur_cmd.act;
          in_frame_id     <= cur_cmd.id;
          in_frame_length <= cur_cmd.len;
          in_frame_data   <= cur_cmd.data;
          in_frame_time   <= cur_cmd.stamp;
          in_location     <= cur_cmd.loc;
        end
      end
      // Exactly one assignment to start per edge, so a back-to-back word keeps it high.
      start <= cmd_live;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result word is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_reports.size() == 0) begin
        $error("result word with no command outstanding, status %0h", out_status);
        fail_count++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", want.status, out_status);
        check_field("out_id", want.id, out_id);
        check_field("out_length", want.len, out_length);
        check_field("out_data", want.data, out_data);
        check_field("out_time", want.stamp, out_time);
        check_field("stored_count", want.count, out_stored_count);
        check_field("stored_total", want.stored, out_stored_total);
        check_field("filtered_total", want.filtered, out_filtered_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes: setup cycle, then access cycle until pready.
  // ---------------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RX_EN:                           shadow_rx_en = value[0];
      REG_ID0, REG_ID1, REG_ID2, REG_ID3:  shadow_id_pairs[idx - REG_ID0] = value[PAIR_W-1:0];
      default:                             shadow_groups[idx - REG_GRP0] = value;
    endcase
  endtask

  task automatic set_filters(logic rx, logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
                             logic [63:0] p3, logic [63:0] g0, logic [63:0] g1,
                             logic [63:0] g2);
    reg_write(REG_RX_EN, {63'd0, rx});
    reg_write(REG_ID0, p0);
    reg_write(REG_ID1, p1);
    reg_write(REG_ID2, p2);
    reg_write(REG_ID3, p3);
    reg_write(REG_GRP0, g0);
    reg_write(REG_GRP1, g1);
    reg_write(REG_GRP2, g2);
    @(negedge clk);
  endtask

  // Waits until the backlog is drained and every predicted word has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (command_backlog.size() != 0 || cmd_live || predicted_reports.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Command word builders.
  // ---------------------------------------------------------------------------
  function automatic can_cmd_t push_cmd(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                        logic [DATA_W-1:0] data, logic [TIME_W-1:0] stamp);
    can_cmd_t c;
    c.act   = ACT_PUSH;
    c.id    = id;
    c.len   = len;
    c.data  = data;
    c.stamp = stamp;
    c.loc   = LOC_W'($urandom);
    return c;
  endfunction

  // Pop and clear ignore the frame fields, so those carry random noise.
  function automatic can_cmd_t bare_cmd(action_t act);
    can_cmd_t c;
    c = push_cmd(ID_W'($urandom), LEN_W'($urandom), {$urandom, $urandom}, $urandom);
    c.act = act;
    return c;
  endfunction

  function automatic can_cmd_t peek_cmd(int loc);
    can_cmd_t c;
    c = bare_cmd(ACT_PEEK);
    c.loc = LOC_W'(loc);
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return LEN_W'(MAX_LEN);
    if (pick < 85) return LEN_W'($urandom_range(0, MAX_LEN));
    return LEN_W'($urandom_range(MAX_LEN + 1, 15));
  endfunction

  // Random 64-bit filter group: a mix of cared-for and don't-care bytes.
  function automatic logic [63:0] random_group();
    logic [63:0] g;
    g = '0;
    if ($urandom_range(0, 3) == 0) return g;
    for (int i = 0; i < BYTES; i++)
      if ($urandom_range(0, 99) < 35) g[8*i +: 8] = 8'($urandom_range(1, 255));
    return g;
  endfunction

  // Random ID pair, with each half left unused now and then. Bits above the
  // slot fields carry noise that the block is expected to ignore.
  function automatic logic [63:0] random_pair();
    logic [63:0] p;
    p = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) p[31:0] = '0;
    if ($urandom_range(0, 2) == 0) p[63:32] = '0;
    return p;
  endfunction

  // A random word aimed at the current filters: frames are mostly built to hit
  // a whitelist slot or a data group, with the rest random or slightly off.
  function automatic can_cmd_t random_command();
    can_cmd_t          c;
    int                pick;
    int                g;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] dat;
    logic [DATA_W-1:0] pat;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) id = id_slot($urandom_range(0, ID_SLOTS_DEF - 1));
      else if (pick < 92) id = ID_W'($urandom);
      else id = ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
      dat = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 50) begin
        g   = $urandom_range(0, GROUPS - 1);
        pat = shadow_groups[g];
        for (int i = 0; i < BYTES; i++)
          if (pat[8*i +: 8] != 8'd0) dat[8*i +: 8] = pat[8*i +: 8];
        if ($urandom_range(0, 99) < 15)
          dat[8*$urandom_range(0, BYTES - 1) +: 8] ^= 8'($urandom_range(1, 255));
      end
      c = push_cmd(id, random_length(), dat, $urandom);
    end else if (pick < 73) begin
      c = bare_cmd(ACT_POP);
    end else if (pick < 95) begin
      c = peek_cmd(($urandom_range(0, 9) < 7) ? $urandom_range(0, 24) : $urandom_range(0, 1023));
    end else begin
      c = bare_cmd(ACT_CLEAR);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int held;
    int pick;
    logic [63:0] ones;
    ones = '1;

    // Shadow reset state; the ring contents are never read before being written.
    shadow_rx_en = 1'b0;
    for (int p = 0; p < ID_PAIRS; p++) shadow_id_pairs[p] = '0;
    for (int g = 0; g < GROUPS; g++) shadow_groups[g] = '0;
    wr_ptr     = '0;
    rd_ptr     = '0;
    stored_cnt = '0;
    reject_cnt = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset receive is off: a push is refused and the ring is empty.
    command_backlog.push_back(push_cmd(ID_MAX, 4'd8, ones, '1));
    command_backlog.push_back(bare_cmd(ACT_POP));
    command_backlog.push_back(peek_cmd(0));
    command_backlog.push_back(peek_cmd(1023));
    command_backlog.push_back(bare_cmd(ACT_CLEAR));
    wait_idle();

    // Receive on, no filters: length handling and peek bounds.
    set_filters(1'b1, '0, '0, '0, '0, '0, '0, '0);
    command_backlog.push_back(push_cmd('0, 4'd0, ones, '0));            // zero length
    command_backlog.push_back(push_cmd(ID_MAX, 4'd15, ones, '1));       // saturates to 8
    command_backlog.push_back(push_cmd(ID_W'($urandom), 4'd3, {$urandom, $urandom}, $urandom));
    command_backlog.push_back(push_cmd(29'h0ABCDEF, 4'd8, 64'h0123_4567_89AB_CDEF, $urandom));
    command_backlog.push_back(peek_cmd(0));
    command_backlog.push_back(peek_cmd(3));
    command_backlog.push_back(peek_cmd(4));                            // equal to the count, one past the last frame
    command_backlog.push_back(bare_cmd(ACT_POP));
    command_backlog.push_back(bare_cmd(ACT_POP));
    wait_idle();

    // Whitelist with slots 0, 1 and 7, and two pattern groups: one that cares
    // about byte 1 only and one that cares about every byte.
    set_filters(1'b1, {3'b0, 29'h1234567, 3'b0, 29'h0000ABC}, '0, '0,
                {3'b0, ID_MAX, 32'd0}, 64'h0000_0000_0000_A500, ones, '0);
    command_backlog.push_back(push_cmd(29'h0000ABC, 4'd8, 64'h1122_3344_5566_A577, $urandom));
    command_backlog.push_back(push_cmd(ID_MAX, 4'd8, ones, $urandom));
    command_backlog.push_back(push_cmd(29'h0001234, 4'd8, 64'h0000_0000_0000_A500, $urandom));
    command_backlog.push_back(push_cmd(29'h0000ABC, 4'd8, 64'h0000_0000_0000_5A00, $urandom));
    // Zero length bypasses both filters even with an unlisted ID.
    command_backlog.push_back(push_cmd(29'h0001234, 4'd0, ones, $urandom));
    // Length one masks byte 1 to zero, so the data group cannot match.
    command_backlog.push_back(push_cmd(29'h0000ABC, 4'd1, 64'h0000_0000_0000_A500, $urandom));
    command_backlog.push_back(peek_cmd(0));
    command_backlog.push_back(bare_cmd(ACT_POP));
    command_backlog.push_back(bare_cmd(ACT_CLEAR));
    command_backlog.push_back(bare_cmd(ACT_POP));
    wait_idle();

    // Fill past capacity with filters off so the ring wraps and overwrites its
    // oldest frames. Every push is stored here, so the fill level is known and
    // peeks can aim at its edge.
    set_filters(1'b1, '0, '0, '0, '0, '0, '0, '0);
    steady_feed = 1'b1;
    command_backlog.push_back(bare_cmd(ACT_CLEAR));
    held = 0;
    for (int i = 0; i < 1060; i++) begin
      command_backlog.push_back(push_cmd(ID_W'($urandom), random_length(),
                                         {$urandom, $urandom}, $urandom));
      if (held < RING_DEPTH - 1) held++;
      if ($urandom_range(0, 99) < 3) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       command_backlog.push_back(peek_cmd(held - 1));
          1:       command_backlog.push_back(peek_cmd(held));
          2:       command_backlog.push_back(peek_cmd(RING_DEPTH - 2));
          default: command_backlog.push_back(peek_cmd($urandom_range(0, 1023)));
        endcase
      end
    end
    command_backlog.push_back(peek_cmd(RING_DEPTH - 2));
    command_backlog.push_back(peek_cmd(RING_DEPTH - 1));
    command_backlog.push_back(bare_cmd(ACT_POP));
    command_backlog.push_back(bare_cmd(ACT_POP));
    wait_idle();
    steady_feed = 1'b0;

    // Random phases: all-ones extremes, receive disabled, then random filters
    // (one of them fed back to back).
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_filters(1'b1, ones, ones, ones, ones, ones, ones, ones);
        1: set_filters(1'b0, random_pair(), random_pair(), random_pair(), random_pair(),
                       random_group(), random_group(), random_group());
        default: set_filters(1'b1, random_pair(), random_pair(), random_pair(), random_pair(),
                             random_group(), random_group(), random_group());
      endcase
      steady_feed = (phase == 3);
      for (int i = 0; i < 75; i++) command_backlog.push_back(random_command());
      wait_idle();
    end
    steady_feed = 1'b0;

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cffq_pkg.sv
rtl/cffq_ram.sv
rtl/cffq_id_lane.sv
rtl/cffq_grp_lane.sv
rtl/cffq_filter.sv
rtl/can_frame_filter_fifo_top.sv
tb/can_frame_filter_fifo_top_tb.sv
